// ----- hdl/rational_arithmetic_unit_top_assert.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rau assertion failed");

// Next-cycle implication.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rau assertion failed");

`endif

// ----- hdl/rau_pkg.sv -----
`default_nettype none
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int VAL_W         = 33;
  localparam int DEN_W         = 31;
  localparam int CNT_W         = $clog2(VAL_W + 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIVZ = 2'd1;
  localparam logic [1:0] STAT_ZDEN = 2'd2;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ----- hdl/rau_gcd.sv -----
`default_nettype none
// Binary gcd: one shift or one compare-subtract per cycle.
module rau_gcd (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rau_pkg::VAL_W-1:0] a_i,
  input  wire logic [rau_pkg::VAL_W-1:0] b_i,
  output rau_pkg::unit_stat_t            stat_o,
  output logic      [rau_pkg::VAL_W-1:0] g_o
);

  logic [rau_pkg::VAL_W-1:0] u_q, v_q;
  logic [rau_pkg::CNT_W-1:0] k_q;
  logic                      busy_q, done_q;
  logic [rau_pkg::VAL_W:0]   diff;

  assign diff = {1'b0, u_q} - {1'b0, v_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && v_q == '0 && k_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= a_i;
      v_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (v_q == '0) begin
        if (k_q != '0) begin
          u_q <= {u_q[rau_pkg::VAL_W-2:0], 1'b0};
          k_q <= k_q - 1'b1;
        end
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (diff[rau_pkg::VAL_W]) begin
        v_q <= v_q - u_q;
      end else begin
        u_q <= v_q;
        v_q <= diff[rau_pkg::VAL_W-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign g_o         = u_q;

endmodule
`default_nettype wire

// ----- hdl/rau_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rau_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rau_pkg::VAL_W-1:0] a_i,
  input  wire logic [rau_pkg::VAL_W-1:0] b_i,
  output rau_pkg::unit_stat_t            stat_o,
  output logic      [rau_pkg::VAL_W-1:0] q_o
);

  logic [rau_pkg::VAL_W-1:0] rem_q, quo_q, den_q;
  logic [rau_pkg::CNT_W-1:0] cnt_q;
  logic                      busy_q, done_q;
  logic [rau_pkg::VAL_W:0]   rem_sh;
  logic [rau_pkg::VAL_W+1:0] diff;

  assign rem_sh = {rem_q, quo_q[rau_pkg::VAL_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == rau_pkg::CNT_W'(rau_pkg::VAL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= a_i;
      den_q <= b_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (!diff[rau_pkg::VAL_W+1]) begin
        rem_q <= diff[rau_pkg::VAL_W-1:0];
        quo_q <= {quo_q[rau_pkg::VAL_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[rau_pkg::VAL_W-1:0];
        quo_q <= {quo_q[rau_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o         = quo_q;

endmodule
`default_nettype wire

// ----- hdl/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit. One word in, one word out. A single shared 16x16
// multiplier forms the three cross products in turn, the combine state merges
// them, then a binary gcd (one shift or subtract per cycle) and two restoring
// divisions reduce the fraction; compare and error cases skip the gcd and the
// divisions and go straight to the result.
// in_stall_o is high from acceptance until the result is written to the
// output register; a finished result waits there while the next word enters.
`default_nettype none
`include "rational_arithmetic_unit_top_assert.svh"
module rational_arithmetic_unit_top (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output logic                                           in_stall_o,
  input  wire logic        [2:0]                         operation_i,
  input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_numerator_i,
  input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_denominator_i,
  input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_numerator_i,
  input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_denominator_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_stall_i,
  output logic signed      [rau_pkg::VAL_W-1:0]          result_numerator_o,
  output logic             [rau_pkg::DEN_W-1:0]          result_denominator_o,
  output logic signed      [1:0]                         order_o,
  output logic             [1:0]                         status_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_COMB = 7'b0000100,
    ST_GCD  = 7'b0001000,
    ST_DIVN = 7'b0010000,
    ST_DIVD = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int VW = rau_pkg::VAL_W;

  state_e state_q, state_d;
  logic [1:0] step_q;

  logic [2:0]                  op_q;
  logic signed [OW-1:0]        an_q, ad_q, bn_q, bd_q;
  logic signed [rau_pkg::PROD_W-1:0] p0_q, p1_q, p2_q, prod;
  logic signed [OW-1:0]        mx, my;
  logic [1:0]                  stat_in_q;
  logic                        bad_op_q;

  logic [VW-1:0]               un_q, ud_q, g_q, qn_q;
  logic                        neg_q;

  logic signed [VW-1:0]        fin_num_q;
  logic [rau_pkg::DEN_W-1:0]   fin_den_q;
  logic [1:0]                  fin_ord_q, fin_stat_q;

  logic signed [VW-1:0]        out_num_q;
  logic [rau_pkg::DEN_W-1:0]   out_den_q;
  logic [1:0]                  out_ord_q, out_stat_q;
  logic                        out_valid_q;

  logic signed [VW-1:0]        n_c, d_c, l_c, r_c;
  logic [VW-1:0]               un_c, ud_c;

  logic                        gcd_start, div_start;
  logic [VW-1:0]               div_a, div_b, gcd_g, div_q;
  rau_pkg::unit_stat_t         gcd_stat, div_stat;

  logic accept, out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // multiplier operand schedule
  always_comb begin
    mx = an_q;
    my = bd_q;
    case (step_q)
      2'd0: begin
        mx = an_q;
        my = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mx = ad_q;
        my = (op_q == rau_pkg::OP_MUL) ? bd_q : (op_q == rau_pkg::OP_DIV) ? bn_q : bn_q;
        if (op_q != rau_pkg::OP_MUL && op_q != rau_pkg::OP_DIV) begin
          mx = bn_q;
          my = ad_q;
        end
      end
      2'd2: begin
        mx = ad_q;
        my = bd_q;
      end
      default: begin
        mx = an_q;
        my = bd_q;
      end
    endcase
  end

  assign prod = mx * my;

  // combine cross products
  always_comb begin
    n_c = VW'(p0_q);
    d_c = VW'(p2_q);
    case (op_q)
      rau_pkg::OP_ADD: n_c = VW'(p0_q) + VW'(p1_q);
      rau_pkg::OP_SUB: n_c = VW'(p0_q) - VW'(p1_q);
      rau_pkg::OP_MUL: d_c = VW'(p1_q);
      rau_pkg::OP_DIV: d_c = VW'(p1_q);
      default:         n_c = VW'(p0_q);
    endcase
    un_c = n_c[VW-1] ? VW'(-n_c) : VW'(n_c);
    ud_c = d_c[VW-1] ? VW'(-d_c) : VW'(d_c);
    if (ad_q[OW-1] ^ bd_q[OW-1]) begin
      l_c = -VW'(p0_q);
      r_c = -VW'(p1_q);
    end else begin
      l_c = VW'(p0_q);
      r_c = VW'(p1_q);
    end
  end

  assign gcd_start = (state_q == ST_COMB) && stat_in_q == rau_pkg::STAT_OK && !bad_op_q
                     && op_q != rau_pkg::OP_CMP && un_c != '0;
  assign div_start = ((state_q == ST_GCD) && gcd_stat.done)
                     || ((state_q == ST_DIVN) && div_stat.done);
  assign div_a = (state_q == ST_GCD) ? un_q : ud_q;
  assign div_b = (state_q == ST_GCD) ? gcd_g : g_q;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (un_c),
    .b_i     (ud_c),
    .stat_o  (gcd_stat),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .stat_o  (div_stat),
    .q_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL:  if (step_q == 2'd2) state_d = ST_COMB;
      ST_COMB: state_d = gcd_start ? ST_GCD : ST_DONE;
      ST_GCD:  if (gcd_stat.done) state_d = ST_DIVN;
      ST_DIVN: if (div_stat.done) state_d = ST_DIVD;
      ST_DIVD: if (div_stat.done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      an_q     <= a_numerator_i;
      ad_q     <= a_denominator_i;
      bn_q     <= b_numerator_i;
      bd_q     <= b_denominator_i;
      bad_op_q <= operation_i > rau_pkg::OP_CMP;
      if (a_denominator_i == '0 || b_denominator_i == '0) begin
        stat_in_q <= rau_pkg::STAT_ZDEN;
      end else if (operation_i == rau_pkg::OP_DIV && b_numerator_i == '0) begin
        stat_in_q <= rau_pkg::STAT_DIVZ;
      end else begin
        stat_in_q <= rau_pkg::STAT_OK;
      end
    end
    if (state_q == ST_MUL) begin
      case (step_q)
        2'd0:    p0_q <= prod;
        2'd1:    p1_q <= prod;
        default: p2_q <= prod;
      endcase
    end
    if (state_q == ST_COMB) begin
      un_q       <= un_c;
      ud_q       <= ud_c;
      neg_q      <= n_c[VW-1] ^ d_c[VW-1];
      fin_num_q  <= '0;
      fin_den_q  <= rau_pkg::DEN_W'(1);
      fin_ord_q  <= rau_pkg::ORD_EQ;
      fin_stat_q <= bad_op_q ? rau_pkg::STAT_OK : stat_in_q;
      if (!bad_op_q && stat_in_q == rau_pkg::STAT_OK && op_q == rau_pkg::OP_CMP) begin
        if (l_c > r_c) begin
          fin_ord_q <= rau_pkg::ORD_GT;
        end else if (l_c < r_c) begin
          fin_ord_q <= rau_pkg::ORD_LT;
        end
      end
    end
    if (state_q == ST_GCD && gcd_stat.done) begin
      g_q <= gcd_g;
    end
    if (state_q == ST_DIVN && div_stat.done) begin
      qn_q <= div_q;
    end
    if (state_q == ST_DIVD && div_stat.done) begin
      fin_num_q <= neg_q ? -qn_q : qn_q;
      fin_den_q <= div_q[rau_pkg::DEN_W-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_num_q  <= fin_num_q;
      out_den_q  <= fin_den_q;
      out_ord_q  <= fin_ord_q;
      out_stat_q <= fin_stat_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_numerator_o   = out_num_q;
  assign result_denominator_o = out_den_q;
  assign order_o              = out_ord_q;
  assign status_o             = out_stat_q;

  `RAU_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, in_stall_o)
  `RAU_ASSERT_NOW(a_den_nonzero, out_valid_o, result_denominator_o != '0)
  `RAU_ASSERT_NOW(a_err_zero_result, out_valid_o && status_o != rau_pkg::STAT_OK,
                  result_numerator_o == '0 && order_o == rau_pkg::ORD_EQ)
  `RAU_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_MUL)
  `RAU_ASSERT_NOW(a_idle_units, state_q == ST_IDLE, !gcd_stat.busy && !div_stat.busy)

endmodule
`default_nettype wire
